// ===== hw/rtl/wlgm_pkg.sv =====
// ----------------------------------------------------------------------------
// wlgm_pkg
// Shared types and constants of the window/level gray mapper.
// ----------------------------------------------------------------------------
package wlgm_pkg;

   localparam int MAG_W  = 40;
   localparam int CTR_W  = 41;
   localparam int ENTRY_W = MAG_W + 1;
   localparam int NUM_W  = 42;
   localparam int QUO_W  = 8;

   // Register indexes of the configuration port.
   localparam logic [1:0] REG_MANUAL = 2'd0;
   localparam logic [1:0] REG_CENTER = 2'd1;
   localparam logic [1:0] REG_WIDTH  = 2'd2;

   // Status codes.
   localparam logic [1:0] ST_OK       = 2'd0;
   localparam logic [1:0] ST_BAD_WIN  = 2'd1;
   localparam logic [1:0] ST_EMPTY    = 2'd2;

   typedef enum logic [2:0] {
      S_IDLE,
      S_SETUP,
      S_DIV,
      S_OUT
   } state_type;

   // Job handed from the controller to the divider.
   typedef struct packed {
      logic              start;
      logic [NUM_W-1:0]  num;
      logic [NUM_W-1:0]  den;
   } div_req_type;

   typedef struct packed {
      logic              done;
      logic [QUO_W-1:0]  quo;
   } div_rsp_type;

endpackage

// ===== hw/rtl/wlgm_ram.sv =====
// ----------------------------------------------------------------------------
// wlgm_ram
// Generic single-port RAM with registered read data.
// ----------------------------------------------------------------------------
module wlgm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] addr,
   input  logic [WIDTH-1:0]         wdata,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // Write on enable; the addressed word is read every cycle, old data during a write.
   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[addr] <= wdata;
      end
      rdata_ff <= mem_ff[addr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/wlgm_div.sv =====
// ----------------------------------------------------------------------------
// wlgm_div
// Restoring divider that yields floor(255*num/den) for num < den, one bit a cycle.
// ----------------------------------------------------------------------------
module wlgm_div (
   input  logic                      clock,
   input  logic                      reset,
   input  wlgm_pkg::div_req_type     req,
   output wlgm_pkg::div_rsp_type     rsp
);
   import wlgm_pkg::*;

   localparam int REM_W = NUM_W + 9;

   logic [REM_W-1:0] rem_ff, rem_in;
   logic [REM_W-1:0] den_ff, den_in;
   logic [QUO_W-1:0] quo_ff, quo_in;
   logic [3:0]       cnt_ff, cnt_in;
   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [REM_W-1:0] trial;

   // One quotient bit per cycle, most significant first.
   always_comb begin
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      trial   = rem_ff - (den_ff << cnt_ff[2:0]);
      if (req.start) begin
         rem_in  = ({9'd0, req.num} << 8) - {9'd0, req.num};
         den_in  = {9'd0, req.den};
         quo_in  = '0;
         cnt_in  = 4'd7;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (!trial[REM_W-1] && (rem_ff >= (den_ff << cnt_ff[2:0]))) begin
            rem_in = trial;
            quo_in[cnt_ff[2:0]] = 1'b1;
         end
         if (cnt_ff == 4'd0) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end else begin
            cnt_in = cnt_ff - 4'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
      cnt_ff <= cnt_in;
   end

   assign rsp.done = done_ff;
   assign rsp.quo  = quo_ff;

endmodule

// ===== hw/rtl/window_level_gray_mapper_unit.sv =====
// ----------------------------------------------------------------------------
// window_level_gray_mapper_unit
// Stores a frame of magnitudes and maps them to gray levels on emit beats.
// ----------------------------------------------------------------------------
//  channel  dir  beat content
//  req_     in   tdata: magnitude[39:0] finite[40]; tuser: mode[0] frame_start[1]
//  rsp_     out  tdata: gray[7:0] status[9:8] frame_min[49:10] frame_max[89:50]
//                tlast: last_pixel
//  csr_     in   write enable, index, 41-bit data
//
// A load beat is written on its accept and the next beat may follow at once.
// An emit that needs the divider passes the store read (overlapping the accept),
// setup, the divider, a step to take the quotient, the output stage and the
// result beat before the next accept; one settled without division skips the
// divider, one on an empty frame goes to the result beat; low rsp_tready delays
// the next accept. Reset is synchronous; store entries are read only once written.
module window_level_gray_mapper_unit #(
   parameter int FRAME_PIXELS = 262144
) (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [47:0]  req_tdata,   // magnitude[39:0], finite[40]
   input  logic [1:0]   req_tuser,   // mode[0], frame_start[1]
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [95:0]  rsp_tdata,   // gray, status, frame_min, frame_max
   output logic         rsp_tlast,
   input  logic         csr_we,
   input  logic [1:0]   csr_index,
   input  logic [40:0]  csr_wdata
);
   import wlgm_pkg::*;

   localparam int AW  = (FRAME_PIXELS > 1) ? $clog2(FRAME_PIXELS) : 1;
   localparam int CW  = $clog2(FRAME_PIXELS + 1);
   localparam logic [CW-1:0] FULL = CW'(FRAME_PIXELS);

   state_type state_ff, state_in;

   logic               manual_ff;
   logic [CTR_W-1:0]   center_ff;
   logic [MAG_W-1:0]   width_ff;
   logic [CW-1:0]      count_ff, count_in;
   logic [CW-1:0]      rptr_ff, rptr_in;
   logic [MAG_W-1:0]   min_ff, min_in, max_ff, max_in;
   logic               anyf_ff, anyf_in;
   logic               last_ff, last_in;
   logic [1:0]         status_ff, status_in;
   logic [7:0]         gray_ff, gray_in;
   logic               ovalid_ff, ovalid_in;
   logic               usediv_ff, usediv_in;
   logic [NUM_W-1:0]   num_ff, num_in, den_ff, den_in;

   logic               ram_we;
   logic [AW-1:0]      ram_addr;
   logic [ENTRY_W-1:0] ram_wdata, ram_rdata;
   div_req_type        dreq;
   div_rsp_type        drsp;

   logic               mode, start, fin;
   logic [MAG_W-1:0]   mag;
   logic [CW-1:0]      ptr;
   logic signed [NUM_W+1:0] low2, m2, diff2;

   assign mag   = req_tdata[39:0];
   assign fin   = req_tdata[40];
   assign mode  = req_tuser[0];
   assign start = req_tuser[1];

   wlgm_ram #(.WIDTH(ENTRY_W), .DEPTH(FRAME_PIXELS)) u_store (
      .clock(clock), .we(ram_we), .addr(ram_addr),
      .wdata(ram_wdata), .rdata(ram_rdata)
   );

   wlgm_div u_div (.clock(clock), .reset(reset), .req(dreq), .rsp(drsp));

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         manual_ff <= 1'b0;
         center_ff <= '0;
         width_ff  <= MAG_W'(256);
      end else if (csr_we) begin
         case (csr_index)
            REG_MANUAL: manual_ff <= csr_wdata[0];
            REG_CENTER: center_ff <= csr_wdata;
            REG_WIDTH:  width_ff  <= csr_wdata[MAG_W-1:0];
            default:    ;
         endcase
      end
   end

   assign req_tready = (state_ff == S_IDLE) && !ovalid_ff;
   assign ptr = (rptr_ff >= count_ff) ? '0 : rptr_ff;
   assign low2  = $signed({center_ff, 1'b0}) - $signed({2'b00, width_ff});
   assign m2    = $signed({3'b000, ram_rdata[MAG_W-1:0], 1'b0});
   assign diff2 = m2 - low2;

   // Controller. The store read of an emit is issued at the accept edge, so
   // its data is ready in the setup stage.
   always_comb begin
      state_in  = state_ff;
      count_in  = count_ff;
      rptr_in   = rptr_ff;
      min_in    = min_ff;
      max_in    = max_ff;
      anyf_in   = anyf_ff;
      last_in   = last_ff;
      status_in = status_ff;
      gray_in   = gray_ff;
      ovalid_in = ovalid_ff;
      usediv_in = usediv_ff;
      num_in    = num_ff;
      den_in    = den_ff;
      ram_we    = 1'b0;
      ram_addr  = ptr[AW-1:0];
      ram_wdata = {fin, mag};
      dreq      = '{start: 1'b0, num: num_ff, den: den_ff};
      if (ovalid_ff && rsp_tready) begin
         ovalid_in = 1'b0;
      end
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid && req_tready) begin
               if (!mode) begin
                  if (start) begin
                     count_in = '0; rptr_in = '0;
                     min_in = '1; max_in = '0; anyf_in = 1'b0;
                  end
                  if ((start ? '0 : count_ff) < FULL) begin
                     ram_we   = 1'b1;
                     ram_addr = start ? '0 : count_ff[AW-1:0];
                     count_in = (start ? '0 : count_ff) + 1'b1;
                     if (fin) begin
                        anyf_in = 1'b1;
                        if (mag < (start ? '1 : min_ff)) min_in = mag;
                        if (mag > (start ? '0 : max_ff)) max_in = mag;
                     end
                  end
               end else if (count_ff == '0) begin
                  gray_in = '0; last_in = 1'b0; status_in = ST_EMPTY;
                  ovalid_in = 1'b1;
               end else begin
                  rptr_in  = ptr + 1'b1;
                  last_in  = (ptr + 1'b1) >= count_ff;
                  if (last_in) rptr_in = '0;
                  state_in = S_SETUP;
               end
            end
         end
         S_SETUP: begin
            usediv_in = 1'b0;
            status_in = ST_OK;
            gray_in   = '0;
            if (manual_ff && width_ff == '0) begin
               status_in = ST_BAD_WIN;
            end else if (!ram_rdata[MAG_W]) begin
               gray_in = '0;
            end else if (manual_ff) begin
               if (diff2 <= 0) gray_in = '0;
               else if (diff2 >= $signed({3'b000, width_ff, 1'b0})) gray_in = 8'd255;
               else begin
                  usediv_in = 1'b1;
                  num_in = diff2[NUM_W-1:0];
                  den_in = {1'b0, width_ff, 1'b0};
               end
            end else if (anyf_ff && max_ff > min_ff) begin
               if (ram_rdata[MAG_W-1:0] <= min_ff) gray_in = '0;
               else if (ram_rdata[MAG_W-1:0] >= max_ff) gray_in = 8'd255;
               else begin
                  usediv_in = 1'b1;
                  num_in = {2'b00, ram_rdata[MAG_W-1:0] - min_ff};
                  den_in = {2'b00, max_ff - min_ff};
               end
            end else begin
               gray_in = (anyf_ff && max_ff != '0) ? 8'd255 : 8'd0;
            end
            state_in = usediv_in ? S_DIV : S_OUT;
            dreq = '{start: usediv_in, num: num_in, den: den_in};
         end
         S_DIV: begin
            if (drsp.done) begin
               gray_in  = drsp.quo;
               state_in = S_OUT;
            end
         end
         S_OUT: begin
            if (!ovalid_ff) begin
               ovalid_in = 1'b1;
               state_in  = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         count_ff  <= '0;
         rptr_ff   <= '0;
         min_ff    <= '1;
         max_ff    <= '0;
         anyf_ff   <= 1'b0;
         ovalid_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         count_ff  <= count_in;
         rptr_ff   <= rptr_in;
         min_ff    <= min_in;
         max_ff    <= max_in;
         anyf_ff   <= anyf_in;
         ovalid_ff <= ovalid_in;
      end
      last_ff   <= last_in;
      status_ff <= status_in;
      gray_ff   <= gray_in;
      usediv_ff <= usediv_in;
      num_ff    <= num_in;
      den_ff    <= den_in;
   end

   assign rsp_tvalid = ovalid_ff;
   assign rsp_tlast  = last_ff;
   assign rsp_tdata  = {6'd0, anyf_ff ? max_ff : '0, anyf_ff ? min_ff : '0,
                        status_ff, gray_ff};

`ifndef SYNTH
   // A result never sits beside a beat in flight.
   a_no_accept_busy: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> !req_tready) else $error("accept while result pending");
   // The fill count never passes the store depth.
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= FULL) else $error("pixel count overflow");
   // A flagged last pixel rewinds the read pointer.
   a_rewind: assert property (@(posedge clock) disable iff (reset)
      (rsp_tvalid && rsp_tlast) |-> rptr_ff == '0) else $error("pointer not rewound");
`endif

endmodule
